@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk_i, held off while the block is in reset.
`define ESE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, held off while the block is in reset.
`define ESE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ese_pkg.sv @@
`timescale 1ns / 1ps

package ese_pkg;

  // Shared multiplier operand and product widths.
  localparam int MulW  = 33;
  localparam int ProdW = 2 * MulW;

  // Division by 3000 as a multiply by ceil(2^43 / 3000) and a shift by 43.
  // Exact for every magnitude up to 2^31.
  localparam int                 RecipShift = 43;
  localparam logic [MulW-1:0]    Recip3000  = 33'd2932031008;

  // Per-unit speed: magnitude below 2^20, plus a sign bit.
  localparam int PuW = 22;

  localparam logic [15:0] RateReset = 16'd1000;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RPM,
    S_DIV,
    S_OLD,
    S_NEW
  } ese_state_e;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_RPM,
    MUL_DIV,
    MUL_OLD,
    MUL_NEW
  } mul_op_e;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic    load_diff;
    mul_op_e op;
    logic    load_rpm;
    logic    load_pu;
    logic    load_term;
    logic    load_out;
  } ese_ctrl_t;

  // Clamp a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] max_v;
    logic signed [ProdW-1:0] min_v;
    max_v = ProdW'(64'sh7FFF_FFFF);
    min_v = -ProdW'(64'sh8000_0000);
    if (v > max_v) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ hdl/encoder_speed_estimator.sv @@
// Each accepted sample passes through the single shared multiplier four times
// (rpm scale, divide by 3000, two filter taps); the last pass loads the result
// beat once the output register has room, and in that pass may accept the next sample.
// Reset clears the sample rate to 1000 Hz and the stored angle and filter
// state to zero; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module encoder_speed_estimator import ese_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample rate register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Angle samples.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] angle_sample, [15] zero
  // Speed results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] raw_speed_rpm, [63:32] filtered_speed_pu
);

  // Folded angle difference: at most 32767 plus one turn, signed.
  localparam int DiffW = ((FRAC_BITS + 2) > 17 ? (FRAC_BITS + 2) : 17) + 1;
  localparam int One   = 1 << FRAC_BITS;

  localparam logic signed [DiffW-1:0] OneD  = DiffW'(One);
  localparam logic signed [DiffW-1:0] HalfD = DiffW'(One / 2);

  localparam int WHiOld = (9 * One) / 10;
  localparam int WHiNew = One / 10;
  localparam int WLoOld = (19 * One) / 20;
  localparam int WLoNew = One / 20;

  localparam logic [MulW-1:0] RpmLimit = MulW'(1000) << FRAC_BITS;

  ese_ctrl_t ctrl;
  logic      out_free;

  logic [15:0]             rate_q;
  logic [14:0]             prev_q;
  logic signed [31:0]      acc_q, acc_d;
  logic signed [DiffW-1:0] diff_q, diff_raw, diff_up, diff_fold;
  logic signed [31:0]      rpm_q;
  logic signed [PuW-1:0]   pu_q, pu_d;
  logic                    hi_q;
  logic signed [33:0]      term_q;
  logic signed [31:0]      raw_q, filt_q;
  logic                    out_valid_q;

  logic [21:0]             rate60;
  logic signed [MulW-1:0]  rpm_mag;
  logic [PuW-2:0]          pu_mag;
  logic signed [MulW-1:0]  op_a, op_b;
  logic signed [ProdW-1:0] prod, rnd;
  logic signed [34:0]      acc_sum;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // Sample rate times 60 as a shift-and-subtract.
  assign rate60 = 22'({rate_q, 6'd0}) - 22'({rate_q, 2'd0});

  // Angle difference folded into plus or minus half a turn, two tests in order.
  assign diff_raw  = DiffW'($signed({1'b0, s_axis_tdata[14:0]}))
                   - DiffW'($signed({1'b0, prev_q}));
  assign diff_up   = (diff_raw < -HalfD) ? diff_raw + OneD : diff_raw;
  assign diff_fold = (diff_up > HalfD) ? diff_up - OneD : diff_up;

  // Magnitude of the saturated rpm, up to 2^31.
  assign rpm_mag = rpm_q[31] ? -MulW'(rpm_q) : MulW'(rpm_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.op)
      MUL_RPM: begin
        op_a = MulW'(diff_q);
        op_b = MulW'({1'b0, rate60});
      end
      MUL_DIV: begin
        op_a = rpm_mag;
        op_b = Recip3000;
      end
      MUL_OLD: begin
        op_a = MulW'(acc_q);
        op_b = hi_q ? MulW'(WHiOld) : MulW'(WLoOld);
      end
      MUL_NEW: begin
        op_a = MulW'(pu_q);
        op_b = hi_q ? MulW'(WHiNew) : MulW'(WLoNew);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ese_mul_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .rnd_o  (rnd)
  );

  // Truncating division of rpm by 3000, sign restored afterwards.
  assign pu_mag = prod[RecipShift +: (PuW - 1)];
  assign pu_d   = rpm_q[31] ? -$signed({1'b0, pu_mag}) : $signed({1'b0, pu_mag});

  // Filter update: sum of both rounded taps, saturated.
  assign acc_sum = 35'(term_q) + 35'($signed(rnd[33:0]));
  assign acc_d   = sat32(ProdW'(acc_sum));

  // Stored angle and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl.load_diff) prev_q <= s_axis_tdata[14:0];
      if (ctrl.load_out)  acc_q  <= acc_d;
    end
  end

  // Working registers between multiplier passes.
  always_ff @(posedge clk_i) begin
    if (ctrl.load_diff) diff_q <= diff_fold;
    if (ctrl.load_rpm)  rpm_q  <= sat32(prod);
    if (ctrl.load_pu) begin
      pu_q <= pu_d;
      hi_q <= rpm_mag > RpmLimit;
    end
    if (ctrl.load_term) term_q <= rnd[33:0];
    if (ctrl.load_out) begin
      raw_q  <= rpm_q;
      filt_q <= acc_d;
    end
  end

  // Output register handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {filt_q, raw_q};

  ese_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // A result beat only appears when the last pass completes.
  `ESE_ASSERT_IMPL(a_result_from_last_pass, $rose(m_axis_tvalid), $past(ctrl.load_out),
    "result beat appeared without a finished filter pass")

  // The filter state changes only when a result is written out.
  `ESE_ASSERT_IMPL(a_acc_only_on_finish, !$past(ctrl.load_out), $stable(acc_q),
    "filter state changed outside the last pass")

  // The output register is loaded only while it is empty or its beat is being taken.
  `ESE_ASSERT_IMPL(a_load_out_needs_room, ctrl.load_out, out_free,
    "output register overwritten before its beat was taken")

endmodule

@@ hdl/ese_mul_unit.sv @@
`timescale 1ns / 1ps

// Shared signed multiplier with a rounded fixed-point result beside the
// full product. Rounding adds half an LSB and floors by FRAC_BITS.
module ese_mul_unit import ese_pkg::*; #(
  parameter int FRAC_BITS = 15
) (
  input  logic signed [MulW-1:0]  op_a_i,
  input  logic signed [MulW-1:0]  op_b_i,
  output logic signed [ProdW-1:0] prod_o,
  output logic signed [ProdW-1:0] rnd_o
);

  localparam logic signed [ProdW-1:0] HalfLsb = ProdW'(1) <<< (FRAC_BITS - 1);

  logic signed [ProdW-1:0] prod;

  // Full-width product.
  assign prod   = op_a_i * op_b_i;
  assign prod_o = prod;

  // Round to nearest, ties upward, by an arithmetic shift.
  assign rnd_o = (prod + HalfLsb) >>> FRAC_BITS;

endmodule

@@ hdl/ese_seq.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sequencer: a sample is accepted while idle or in the last pass, then four passes through the shared multiplier.
module ese_seq import ese_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  output logic      in_ready_o,
  output ese_ctrl_t ctrl_o
);

  ese_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. The last pass waits for room in the output register and
  // may take the next sample in the same cycle.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RPM;
      end
      S_RPM: state_d = S_DIV;
      S_DIV: state_d = S_OLD;
      S_OLD: state_d = S_NEW;
      S_NEW: begin
        if (out_free_i) begin
          state_d = in_valid_i ? S_RPM : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o       = 1'b0;
    ctrl_o           = '0;
    ctrl_o.op        = MUL_RPM;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_RPM: begin
        ctrl_o.op       = MUL_RPM;
        ctrl_o.load_rpm = 1'b1;
      end
      S_DIV: begin
        ctrl_o.op      = MUL_DIV;
        ctrl_o.load_pu = 1'b1;
      end
      S_OLD: begin
        ctrl_o.op        = MUL_OLD;
        ctrl_o.load_term = 1'b1;
      end
      S_NEW: begin
        ctrl_o.op       = MUL_NEW;
        ctrl_o.load_out = out_free_i;
        in_ready_o      = out_free_i;
      end
      default: in_ready_o = 1'b0;
    endcase
    ctrl_o.load_diff = in_ready_o & in_valid_i;
  end

  // An accepted sample always starts the rpm pass next.
  `ESE_ASSERT_NEXT(a_accept_starts_rpm, in_valid_i && in_ready_o, state_q == S_RPM,
    "accepted sample did not start the rpm pass")

  // Taking a sample while finishing the previous one needs a free output register.
  `ESE_ASSERT_IMPL(a_overlap_needs_room, in_ready_o && (state_q != S_IDLE), out_free_i,
    "ready raised while the output register is blocked")

endmodule
